FILE: rtl/kuf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kuf_pkg;

    // Vertex count of the link table; a power of two, so an index wraps by masking.
    localparam int VERTICES = 1024;
    localparam int VIDX_W   = $clog2(VERTICES);
    localparam int CNT_W    = $clog2(VERTICES + 1);
    localparam int VERT_W   = 10;
    localparam int WEIGHT_W = 16;

    // A root holds its count; a child holds its parent index in the low bits of val.
    typedef struct packed {
        logic             is_root;
        logic [CNT_W-1:0] val;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [VIDX_W-1:0] vert_idx(input logic [VERT_W-1:0] v);
        logic [VERT_W+VIDX_W-1:0] wide;
        wide = {{VIDX_W{1'b0}}, v};
        return wide[VIDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/kuf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module kuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/kruskal_union_find_edge_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Union-find edge filter for Kruskal's spanning tree.
// Command channel: an item (mode, vert_a, vert_b, edge_weight) is taken at a
// rising edge with start high and busy low. mode 0 clears every vertex to a
// single root; mode 1 offers an edge. Offer edges in nondecreasing weight order.
// Result: done is high for exactly one cycle with accepted, out_vert_a,
// out_vert_b and out_weight valid; the receiver cannot hold it off. A clear
// item returns an all-zero result.
// Timing: an edge walks both parent chains through the link table's one read
// port, one link per cycle: busy covers the walk of chain a, the walk of chain
// b and the union step, plus a second write step when two trees merge; done
// follows in the next cycle, when busy is already low and the next item may be
// taken. A clear item sweeps the table one entry a cycle while busy, then done.
// Reset: the same sweep runs after reset with busy high and produces no result.
module kruskal_union_find_edge_filter
    import kuf_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                mode,
    input  wire logic [VERT_W-1:0]   vert_a,
    input  wire logic [VERT_W-1:0]   vert_b,
    input  wire logic [WEIGHT_W-1:0] edge_weight,
    output logic                     done,
    output logic                     accepted,
    output logic [VERT_W-1:0]        out_vert_a,
    output logic [VERT_W-1:0]        out_vert_b,
    output logic [WEIGHT_W-1:0]      out_weight
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_WALK_A = 3'd2;
    localparam logic [2:0] ST_WALK_B = 3'd3;
    localparam logic [2:0] ST_UNION  = 3'd4;
    localparam logic [2:0] ST_LINK2  = 3'd5;

    localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(VERTICES - 1);

    logic [2:0]          state_reg, state_next;
    logic [VIDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                clr_item_reg, clr_item_next;
    logic                done_reg, done_next;
    logic                accepted_reg, accepted_next;
    logic [VERT_W-1:0]   va_reg, va_next;
    logic [VERT_W-1:0]   vb_reg, vb_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic [VIDX_W-1:0]   cur_reg, cur_next;
    logic [VIDX_W-1:0]   root_a_reg, root_a_next;
    logic [VIDX_W-1:0]   root_b_reg, root_b_next;
    logic [CNT_W-1:0]    cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]    cnt_b_reg, cnt_b_next;
    logic [VIDX_W-1:0]   surv_reg, surv_next;
    logic [CNT_W-1:0]    surv_cnt_reg, surv_cnt_next;

    logic                ram_we;
    logic [VIDX_W-1:0]   ram_waddr;
    entry_t              ram_wentry;
    logic [VIDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    entry_t              rd_entry;
    logic [VIDX_W-1:0]   rd_parent;

    kuf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (VERTICES)
    ) u_link_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = entry_t'(ram_rdata);
    assign rd_parent = rd_entry.val[VIDX_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_item_next = clr_item_reg;
        done_next     = 1'b0;
        accepted_next = accepted_reg;
        va_next       = va_reg;
        vb_next       = vb_reg;
        w_next        = w_reg;
        cur_next      = cur_reg;
        root_a_next   = root_a_reg;
        root_b_next   = root_b_reg;
        cnt_a_next    = cnt_a_reg;
        cnt_b_next    = cnt_b_reg;
        surv_next     = surv_reg;
        surv_cnt_next = surv_cnt_reg;
        ram_we        = 1'b0;
        ram_waddr     = clr_cnt_reg;
        ram_wentry    = '{is_root: 1'b1, val: CNT_W'(1)};
        ram_raddr     = cur_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (mode)
                    begin
                        va_next    = vert_a;
                        vb_next    = vert_b;
                        w_next     = edge_weight;
                        cur_next   = vert_idx(vert_a);
                        ram_raddr  = vert_idx(vert_a);
                        state_next = ST_WALK_A;
                    end
                    else
                    begin
                        va_next       = '0;
                        vb_next       = '0;
                        w_next        = '0;
                        accepted_next = 1'b0;
                        clr_cnt_next  = '0;
                        clr_item_next = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_IDX)
                begin
                    done_next     = clr_item_reg;
                    clr_item_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            ST_WALK_A:
            begin
                if (rd_entry.is_root)
                begin
                    root_a_next = cur_reg;
                    cnt_a_next  = rd_entry.val;
                    cur_next    = vert_idx(vb_reg);
                    ram_raddr   = vert_idx(vb_reg);
                    state_next  = ST_WALK_B;
                end
                else
                begin
                    // Follow the parent link; its entry arrives next cycle.
                    cur_next  = rd_parent;
                    ram_raddr = rd_parent;
                end
            end
            ST_WALK_B:
            begin
                if (rd_entry.is_root)
                begin
                    root_b_next = cur_reg;
                    cnt_b_next  = rd_entry.val;
                    state_next  = ST_UNION;
                end
                else
                begin
                    cur_next  = rd_parent;
                    ram_raddr = rd_parent;
                end
            end
            ST_UNION:
            begin
                if (root_a_reg == root_b_reg)
                begin
                    accepted_next = 1'b0;
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    // Hang the smaller-or-equal root under the other one.
                    ram_we        = 1'b1;
                    accepted_next = 1'b1;
                    state_next    = ST_LINK2;
                    if (cnt_a_reg <= cnt_b_reg)
                    begin
                        ram_waddr     = root_a_reg;
                        ram_wentry    = '{is_root: 1'b0, val: CNT_W'(root_b_reg)};
                        surv_next     = root_b_reg;
                        surv_cnt_next = cnt_b_reg + 1'b1;
                    end
                    else
                    begin
                        ram_waddr     = root_b_reg;
                        ram_wentry    = '{is_root: 1'b0, val: CNT_W'(root_a_reg)};
                        surv_next     = root_a_reg;
                        surv_cnt_next = cnt_a_reg + 1'b1;
                    end
                end
            end
            ST_LINK2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = surv_reg;
                ram_wentry = '{is_root: 1'b1, val: surv_cnt_reg};
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            clr_item_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_item_reg <= clr_item_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted_reg <= accepted_next;
        va_reg       <= va_next;
        vb_reg       <= vb_next;
        w_reg        <= w_next;
        cur_reg      <= cur_next;
        root_a_reg   <= root_a_next;
        root_b_reg   <= root_b_next;
        cnt_a_reg    <= cnt_a_next;
        cnt_b_reg    <= cnt_b_next;
        surv_reg     <= surv_next;
        surv_cnt_reg <= surv_cnt_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign accepted   = accepted_reg;
    assign out_vert_a = va_reg;
    assign out_vert_b = vb_reg;
    assign out_weight = w_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not start work");

    a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> busy)
        else $error("link table written while idle");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire
